[rtl/gpr_pkg.sv]
// ----------------------------------------------------------------------------
// GPIO port register package
// Shared types, register codes and helpers of the GPIO port register block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpr_pkg;

  localparam int unsigned NUM_PINS  = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned KEY_BIT   = 16;
  localparam logic [DATA_W-1:0] CFG_RESET = 32'h4444_4444;

  typedef enum logic {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    REG_CFG_LOW  = 3'd0,
    REG_CFG_HIGH = 3'd1,
    REG_INPUT    = 3'd2,
    REG_OUTPUT   = 3'd3,
    REG_SET_RST  = 3'd4,
    REG_RESET    = 3'd5,
    REG_LOCK     = 3'd6,
    REG_UNUSED   = 3'd7
  } reg_index_t;

  typedef enum logic [1:0] {
    KEY_IDLE   = 2'd0,
    KEY_FIRST  = 2'd1,
    KEY_SECOND = 2'd2,
    KEY_THIRD  = 2'd3
  } key_step_t;

  typedef struct packed {
    cmd_t                command;
    reg_index_t          register_index;
    logic [DATA_W-1:0]   write_data;
    logic [NUM_PINS-1:0] pin_levels;
  } access_t;

  typedef struct packed {
    logic [DATA_W-1:0]   read_data;
    logic [NUM_PINS-1:0] output_levels;
    logic                lock_active;
  } result_t;

  typedef struct packed {
    logic      lock_key;
    key_step_t key_step;
  } lock_status_t;

  // Spreads eight pin lock bits over the matching 4-bit config fields.
  function automatic logic [DATA_W-1:0] nibble_mask(input logic [7:0] pins);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      m[4*i +: 4] = {4{pins[i]}};
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/gpr_regs.sv]
// ----------------------------------------------------------------------------
// GPIO port register file
// Holds the port registers and lock sequencer and works out one access.
// ----------------------------------------------------------------------------
`default_nettype none

module gpr_regs
  import gpr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         fire,
  input  wire access_t      acc,
  output result_t           res,
  output lock_status_t      status
);

  logic [DATA_W-1:0]   cfg_lo_r, cfg_lo_nxt;
  logic [DATA_W-1:0]   cfg_hi_r, cfg_hi_nxt;
  logic [NUM_PINS-1:0] out_data_r, out_data_nxt;
  logic [NUM_PINS-1:0] lock_mask_r, lock_mask_nxt;
  logic                lock_key_r, lock_key_nxt;
  key_step_t           key_step_r, key_step_nxt;
  logic [NUM_PINS-1:0] key_pins_r, key_pins_nxt;

  logic [DATA_W-1:0]   prot_lo;
  logic [DATA_W-1:0]   prot_hi;
  logic [DATA_W-1:0]   rd;
  logic [NUM_PINS-1:0] wr_pins;
  logic                wr_key;
  logic                pins_match;

  assign wr_pins    = acc.write_data[NUM_PINS-1:0];
  assign wr_key     = acc.write_data[KEY_BIT];
  assign pins_match = (wr_pins == key_pins_r);
  assign prot_lo    = lock_key_r ? nibble_mask(lock_mask_r[7:0]) : '0;
  assign prot_hi    = lock_key_r ? nibble_mask(lock_mask_r[15:8]) : '0;

  always_comb begin
    cfg_lo_nxt    = cfg_lo_r;
    cfg_hi_nxt    = cfg_hi_r;
    out_data_nxt  = out_data_r;
    lock_mask_nxt = lock_mask_r;
    lock_key_nxt  = lock_key_r;
    key_step_nxt  = key_step_r;
    key_pins_nxt  = key_pins_r;
    rd            = '0;
    if (acc.command == CMD_WRITE) begin
      case (acc.register_index)
        REG_CFG_LOW:  cfg_lo_nxt = (cfg_lo_r & prot_lo) | (acc.write_data & ~prot_lo);
        REG_CFG_HIGH: cfg_hi_nxt = (cfg_hi_r & prot_hi) | (acc.write_data & ~prot_hi);
        REG_OUTPUT:   out_data_nxt = wr_pins;
        REG_SET_RST:  out_data_nxt = (out_data_r & ~acc.write_data[DATA_W-1:NUM_PINS]) | wr_pins;
        REG_RESET:    out_data_nxt = out_data_r & ~wr_pins;
        REG_LOCK: begin
          // Once the key is set the lock register is frozen.
          if (!lock_key_r) begin
            lock_mask_nxt = wr_pins;
            if (wr_key) begin
              if (key_step_r == KEY_SECOND && pins_match) begin
                key_step_nxt = KEY_THIRD;
              end else begin
                key_step_nxt = KEY_FIRST;
                key_pins_nxt = wr_pins;
              end
            end else if (key_step_r == KEY_FIRST && pins_match) begin
              key_step_nxt = KEY_SECOND;
            end else begin
              key_step_nxt = KEY_IDLE;
            end
          end
        end
        default: ;
      endcase
    end else begin
      case (acc.register_index)
        REG_CFG_LOW:  rd = cfg_lo_r;
        REG_CFG_HIGH: rd = cfg_hi_r;
        REG_INPUT:    rd = {{(DATA_W-NUM_PINS){1'b0}}, acc.pin_levels};
        REG_OUTPUT:   rd = {{(DATA_W-NUM_PINS){1'b0}}, out_data_r};
        REG_LOCK: begin
          // The read that completes the sequence still shows the old key bit.
          rd = {{(DATA_W-NUM_PINS-1){1'b0}}, lock_key_r, lock_mask_r};
          if (!lock_key_r && key_step_r == KEY_THIRD) begin
            lock_key_nxt = 1'b1;
          end
          key_step_nxt = KEY_IDLE;
        end
        default: rd = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_lo_r    <= CFG_RESET;
      cfg_hi_r    <= CFG_RESET;
      out_data_r  <= '0;
      lock_mask_r <= '0;
      lock_key_r  <= 1'b0;
      key_step_r  <= KEY_IDLE;
      key_pins_r  <= '0;
    end else if (fire) begin
      cfg_lo_r    <= cfg_lo_nxt;
      cfg_hi_r    <= cfg_hi_nxt;
      out_data_r  <= out_data_nxt;
      lock_mask_r <= lock_mask_nxt;
      lock_key_r  <= lock_key_nxt;
      key_step_r  <= key_step_nxt;
      key_pins_r  <= key_pins_nxt;
    end
  end

  assign res.read_data     = rd;
  assign res.output_levels = out_data_nxt;
  assign res.lock_active   = lock_key_nxt;

  assign status.lock_key = lock_key_r;
  assign status.key_step = key_step_r;

endmodule

`default_nettype wire

[rtl/gpio_port_registers_with_lock_top.sv]
// ----------------------------------------------------------------------------
// GPIO port registers with lock
// Sixteen-pin GPIO port register block driven by one bus access per beat.
// ----------------------------------------------------------------------------
// The input channel carries one register access per beat: a read or a write
// command, a register index, the write word and the sampled pin levels.
// The result channel returns one beat per access with the read data (zero on
// a write), the output data register after the access and the lock flag.
// An accepted beat is held in an input register; from there the register
// file works it out and the result is loaded into the output register,
// which offers it. Throughput is one access per cycle while the receiver
// does not stall, set by the single pass through the register file between
// the input and output registers.
// When the receiver stalls, the output register holds its beat and the input
// register can still take one more access; only with both full is the input
// channel stalled. Reset restores the config words to floating inputs, clears
// the output data, the lock mask, the lock key and any key sequence, and
// empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_port_registers_with_lock_top
  import gpr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_command,
  input  wire logic [2:0]          in_register_index,
  input  wire logic [DATA_W-1:0]   in_write_data,
  input  wire logic [NUM_PINS-1:0] in_pin_levels,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [DATA_W-1:0]        out_read_data,
  output logic [NUM_PINS-1:0]      out_output_levels,
  output logic                     out_lock_active
);

  logic         s1_valid_r, s1_valid_nxt;
  access_t      s1_acc_r;
  logic         out_valid_r, out_valid_nxt;
  result_t      out_res_r;
  logic         out_load;
  logic         s1_fire;
  logic         in_accept;
  result_t      res;
  lock_status_t status;

  assign out_load  = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_load;
  assign in_stall  = s1_valid_r && !out_load;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = s1_fire || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_acc_r.command        <= cmd_t'(in_command);
      s1_acc_r.register_index <= reg_index_t'(in_register_index);
      s1_acc_r.write_data     <= in_write_data;
      s1_acc_r.pin_levels     <= in_pin_levels;
    end
    if (s1_fire) begin
      out_res_r <= res;
    end
  end

  gpr_regs u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (s1_fire),
    .acc    (s1_acc_r),
    .res    (res),
    .status (status)
  );

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_res_r.read_data;
  assign out_output_levels = out_res_r.output_levels;
  assign out_lock_active   = out_res_r.lock_active;

  // Once locked, no key sequence can be in progress.
  assert property (@(posedge clk) disable iff (!rst_n)
    status.lock_key |-> status.key_step == KEY_IDLE)
    else $error("key sequence active while locked");

  // The lock is only cleared by reset.
  assert property (@(posedge clk) disable iff (!rst_n)
    status.lock_key |=> status.lock_key)
    else $error("lock key cleared without reset");

  // A held access is never dropped while the output side is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && out_stall |=> s1_valid_r)
    else $error("pending access lost under stall");

  // The input side is only stalled when the input register is occupied.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with free space");

endmodule

`default_nettype wire

[test/gpio_port_registers_with_lock_top_tb.sv]
// ----------------------------------------------------------------------------
// GPIO port register block testbench
// Drives register reads and writes through the valid/stall input channel and
// checks every result beat against a cycle-free model of the port registers.
// The run walks through broken lock key sequences with the lock still open,
// then completes the key sequence once and keeps going under the lock.
// ----------------------------------------------------------------------------

module gpio_port_registers_with_lock_top_tb
  import gpr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPEN_PORT_ITEMS = 1200;
  localparam int TOTAL_ITEMS     = 1650;
  localparam int HOLD_OFF_CYCLES = 48;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int PRINT_CAP       = 40;

  // Keeps its own copy of the port registers and the queue of result beats
  // still owed by the block.
  class gpio_reg_scoreboard;
    logic [DATA_W-1:0]   cfg_low;
    logic [DATA_W-1:0]   cfg_high;
    logic [NUM_PINS-1:0] out_data;
    logic [NUM_PINS-1:0] pin_lock;
    logic [NUM_PINS-1:0] key_pins;
    logic                locked;
    key_step_t           key_phase;
    result_t             expected_beats[$];
    int                  fail_count;
    int                  beats_checked;

    function new();
      cfg_low       = CFG_RESET;
      cfg_high      = CFG_RESET;
      out_data      = '0;
      pin_lock      = '0;
      key_pins      = '0;
      locked        = 1'b0;
      key_phase     = KEY_IDLE;
      fail_count    = 0;
      beats_checked = 0;
    endfunction

    task report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      fail_count++;
      if (fail_count <= PRINT_CAP) begin
        $display("[%0t] MISMATCH %s: got %08h, want %08h", $time, what, got, want);
      end
    endtask

    // Bits of a config word whose pin is locked, so a write leaves them alone.
    function logic [DATA_W-1:0] field_guard(logic [7:0] pins);
      logic [DATA_W-1:0] g;
      for (int b = 0; b < DATA_W; b++) begin
        g[b] = locked & pins[b / 4];
      end
      return g;
    endfunction

    function void write_lock(logic [DATA_W-1:0] d);
      if (locked) begin
        return;
      end
      pin_lock = d[15:0];
      if (d[KEY_BIT]) begin
        if (key_phase == KEY_SECOND && d[15:0] == key_pins) begin
          key_phase = KEY_THIRD;
        end else begin
          key_phase = KEY_FIRST;
          key_pins  = d[15:0];
        end
      end else if (key_phase == KEY_FIRST && d[15:0] == key_pins) begin
        key_phase = KEY_SECOND;
      end else begin
        key_phase = KEY_IDLE;
      end
    endfunction

    function result_t apply_access(access_t a);
      result_t           r;
      logic [DATA_W-1:0] guard;
      r.read_data = '0;
      if (a.command == CMD_WRITE) begin
        case (a.register_index)
          REG_CFG_LOW: begin
            guard   = field_guard(pin_lock[7:0]);
            cfg_low = (cfg_low & guard) | (a.write_data & ~guard);
          end
          REG_CFG_HIGH: begin
            guard    = field_guard(pin_lock[15:8]);
            cfg_high = (cfg_high & guard) | (a.write_data & ~guard);
          end
          REG_OUTPUT:  out_data = a.write_data[15:0];
          REG_SET_RST: out_data = (out_data & ~a.write_data[31:16]) | a.write_data[15:0];
          REG_RESET:   out_data = out_data & ~a.write_data[15:0];
          REG_LOCK:    write_lock(a.write_data);
          default: ;
        endcase
      end else begin
        case (a.register_index)
          REG_CFG_LOW:  r.read_data = cfg_low;
          REG_CFG_HIGH: r.read_data = cfg_high;
          REG_INPUT:    r.read_data = {16'h0, a.pin_levels};
          REG_OUTPUT:   r.read_data = {16'h0, out_data};
          REG_LOCK: begin
            // The read that completes the key still shows the key bit clear.
            r.read_data = {15'h0, locked, pin_lock};
            if (!locked && key_phase == KEY_THIRD) begin
              locked = 1'b1;
            end
            key_phase = KEY_IDLE;
          end
          default: r.read_data = '0;
        endcase
      end
      r.output_levels = out_data;
      r.lock_active   = locked;
      return r;
    endfunction

    function void note_access(access_t a);
      expected_beats.push_back(apply_access(a));
    endfunction

    task check_result(result_t got);
      result_t want;
      if (expected_beats.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", got.read_data, '0);
        return;
      end
      want = expected_beats.pop_front();
      beats_checked++;
      if (got.read_data !== want.read_data) begin
        report_mismatch("read_data", got.read_data, want.read_data);
      end
      if (got.output_levels !== want.output_levels) begin
        report_mismatch("output_levels", {16'h0, got.output_levels},
                        {16'h0, want.output_levels});
      end
      if (got.lock_active !== want.lock_active) begin
        report_mismatch("lock_active", {31'h0, got.lock_active}, {31'h0, want.lock_active});
      end
    endtask

    task flush_leftovers();
      while (expected_beats.size() != 0) begin
        report_mismatch("result beat never arrived", '0,
                        expected_beats.pop_front().read_data);
      end
    endtask
  endclass

  logic                clk;
  logic                rst_n             = 1'b0;
  logic                in_valid          = 1'b0;
  logic                in_stall;
  logic                in_command        = 1'b0;
  logic [2:0]          in_register_index = '0;
  logic [DATA_W-1:0]   in_write_data     = '0;
  logic [NUM_PINS-1:0] in_pin_levels     = '0;
  logic                out_valid;
  logic                out_stall         = 1'b0;
  logic [DATA_W-1:0]   out_read_data;
  logic [NUM_PINS-1:0] out_output_levels;
  logic                out_lock_active;

  gpio_reg_scoreboard  board;
  int                  items_sent  = 0;
  int                  burst_left  = 0;
  int                  quiet_cycles = 0;
  logic [NUM_PINS-1:0] lock_pins;

  gpio_port_registers_with_lock_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_register_index (in_register_index),
    .in_write_data     (in_write_data),
    .in_pin_levels     (in_pin_levels),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .out_output_levels (out_output_levels),
    .out_lock_active   (out_lock_active)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin : beat_monitor
    access_t seen;
    result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        seen.command        = cmd_t'(in_command);
        seen.register_index = reg_index_t'(in_register_index);
        seen.write_data     = in_write_data;
        seen.pin_levels     = in_pin_levels;
        board.note_access(seen);
      end
      if (out_valid && !out_stall) begin
        got.read_data     = out_read_data;
        got.output_levels = out_output_levels;
        got.lock_active   = out_lock_active;
        board.check_result(got);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
          $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
          $display("Regression FAIL");
          $finish;
        end
      end
    end
  end

  // Receiver stall pattern: a free-running start, one long hold-off so the
  // block fills and stalls its input, then random segments.
  initial begin : stall_pattern
    int span;
    int pct;
    int shape;
    while (!rst_n) @(posedge clk);
    repeat (120) @(posedge clk);
    out_stall <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    forever begin
      shape = $urandom_range(0, 9);
      span  = $urandom_range(5, 60);
      pct   = $urandom_range(10, 80);
      if (shape == 9) begin
        span = $urandom_range(30, 60);
      end else if (shape == 8) begin
        span = $urandom_range(1, 6);
      end
      repeat (span) begin
        if (shape <= 3) begin
          out_stall <= 1'b0;
        end else if (shape <= 7) begin
          out_stall <= ($urandom_range(1, 100) <= pct);
        end else begin
          out_stall <= 1'b1;
        end
        @(posedge clk);
      end
    end
  end

  function automatic logic [DATA_W-1:0] shaped_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [NUM_PINS-1:0] shaped_pins();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return NUM_PINS'($urandom);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] key_word(logic key, logic [NUM_PINS-1:0] pins);
    logic [DATA_W-1:0] w;
    w          = $urandom;
    w[15:0]    = pins;
    w[KEY_BIT] = key;
    return w;
  endfunction

  // Offers one beat and returns at the edge where it is taken. The sender
  // runs in bursts with random gaps in between.
  task automatic send_access(cmd_t c, reg_index_t r, logic [DATA_W-1:0] d,
                             logic [NUM_PINS-1:0] p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid          <= 1'b1;
    in_command        <= c;
    in_register_index <= r;
    in_write_data     <= d;
    in_pin_levels     <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Random accesses that never touch the lock register.
  task automatic send_filler(int count);
    int idx;
    repeat (count) begin
      idx = $urandom_range(0, 6);
      if (idx == REG_LOCK) begin
        idx = REG_UNUSED;
      end
      send_access(cmd_t'($urandom_range(0, 1)), reg_index_t'(idx), shaped_word(),
                  shaped_pins());
    end
  endtask

  // A key sequence that is broken at some step, so the port stays open.
  task automatic key_attempt();
    logic [NUM_PINS-1:0] pins;
    logic [NUM_PINS-1:0] flip;
    int                  shape;
    pins  = shaped_pins();
    flip  = 16'h1 << $urandom_range(0, 15);
    shape = $urandom_range(0, 4);
    send_access(CMD_WRITE, REG_LOCK, key_word(1'b1, pins), shaped_pins());
    send_filler($urandom_range(0, 2));
    if (shape == 0) begin
      send_access(CMD_READ, REG_LOCK, $urandom, shaped_pins());
      return;
    end
    if (shape == 1) begin
      send_access(CMD_WRITE, REG_LOCK, key_word(1'b0, pins ^ flip), shaped_pins());
      return;
    end
    send_access(CMD_WRITE, REG_LOCK, key_word(1'b0, pins), shaped_pins());
    send_filler($urandom_range(0, 2));
    case (shape)
      2: send_access(CMD_WRITE, REG_LOCK, key_word(1'b1, pins ^ flip), shaped_pins());
      3: begin
        send_access(CMD_WRITE, REG_LOCK, key_word(1'b1, pins), shaped_pins());
        send_filler($urandom_range(0, 3));
        send_access(CMD_WRITE, REG_LOCK, key_word(1'b0, shaped_pins()), shaped_pins());
      end
      default: begin
        send_access(CMD_WRITE, REG_LOCK, key_word(1'b1, pins), shaped_pins());
        send_access(CMD_WRITE, REG_LOCK, key_word(1'b1, pins), shaped_pins());
      end
    endcase
    send_access(CMD_READ, REG_LOCK, $urandom, shaped_pins());
  endtask

  initial begin : stimulus
    int locked_from;
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values, every register read, set beating reset, ignored writes.
    send_access(CMD_READ,  REG_CFG_LOW,  '0, shaped_pins());
    send_access(CMD_READ,  REG_CFG_HIGH, '1, shaped_pins());
    send_access(CMD_READ,  REG_INPUT,    '0, 16'hFFFF);
    send_access(CMD_READ,  REG_INPUT,    '1, 16'h0000);
    send_access(CMD_READ,  REG_OUTPUT,   '0, shaped_pins());
    send_access(CMD_READ,  REG_SET_RST,  '0, shaped_pins());
    send_access(CMD_READ,  REG_RESET,    '0, shaped_pins());
    send_access(CMD_READ,  REG_LOCK,     '0, shaped_pins());
    send_access(CMD_READ,  REG_UNUSED,   '0, shaped_pins());
    send_access(CMD_WRITE, REG_CFG_LOW,  32'hFFFF_FFFF, shaped_pins());
    send_access(CMD_WRITE, REG_CFG_HIGH, 32'h0000_0000, shaped_pins());
    send_access(CMD_READ,  REG_CFG_LOW,  '0, shaped_pins());
    send_access(CMD_WRITE, REG_OUTPUT,   32'hFFFF_A5A5, shaped_pins());
    send_access(CMD_WRITE, REG_SET_RST,  32'hFFFF_00FF, shaped_pins());
    send_access(CMD_WRITE, REG_RESET,    32'hFFFF_000F, shaped_pins());
    send_access(CMD_WRITE, REG_INPUT,    32'hFFFF_FFFF, shaped_pins());
    send_access(CMD_WRITE, REG_UNUSED,   32'hFFFF_FFFF, shaped_pins());
    send_access(CMD_READ,  REG_UNUSED,   '1, shaped_pins());
    // Lock read before the third key write aborts; a late write breaks a
    // sequence that had reached its third step.
    send_access(CMD_WRITE, REG_LOCK,     32'h0001_FFFF, shaped_pins());
    send_access(CMD_READ,  REG_LOCK,     '0, shaped_pins());
    send_access(CMD_WRITE, REG_LOCK,     32'h0001_0000, shaped_pins());
    send_access(CMD_WRITE, REG_LOCK,     32'hFFFE_0000, shaped_pins());
    send_access(CMD_WRITE, REG_LOCK,     32'h0001_0000, shaped_pins());
    send_access(CMD_WRITE, REG_LOCK,     32'h0000_0001, shaped_pins());
    send_access(CMD_READ,  REG_LOCK,     '0, shaped_pins());

    // Open port: mostly key sequences with random content, some noise.
    while (items_sent < OPEN_PORT_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: key_attempt();
        6, 7:             send_filler($urandom_range(1, 4));
        default: begin
          if ($urandom_range(0, 1) == 1) begin
            send_access(CMD_READ, REG_LOCK, $urandom, shaped_pins());
          end else begin
            send_access(CMD_WRITE, REG_LOCK, key_word(1'b0, shaped_pins()), shaped_pins());
          end
        end
      endcase
    end

    // The one completed key sequence of the run.
    lock_pins = NUM_PINS'($urandom);
    send_access(CMD_WRITE, REG_LOCK, key_word(1'b1, lock_pins), shaped_pins());
    send_filler($urandom_range(0, 2));
    send_access(CMD_WRITE, REG_LOCK, key_word(1'b0, lock_pins), shaped_pins());
    send_filler($urandom_range(0, 2));
    send_access(CMD_WRITE, REG_LOCK, key_word(1'b1, lock_pins), shaped_pins());
    send_filler($urandom_range(0, 2));
    send_access(CMD_READ,  REG_LOCK, '0, shaped_pins());
    send_access(CMD_READ,  REG_LOCK, '0, shaped_pins());
    send_access(CMD_WRITE, REG_CFG_LOW,  32'hFFFF_FFFF, shaped_pins());
    send_access(CMD_WRITE, REG_CFG_HIGH, 32'h0000_0000, shaped_pins());
    send_access(CMD_READ,  REG_CFG_LOW,  '0, shaped_pins());
    send_access(CMD_READ,  REG_CFG_HIGH, '0, shaped_pins());
    locked_from = items_sent;

    // Locked port: anything goes, lock writes included.
    while (items_sent < TOTAL_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        key_attempt();
      end else begin
        send_access(cmd_t'($urandom_range(0, 1)), reg_index_t'($urandom_range(0, 7)),
                    shaped_word(), shaped_pins());
      end
    end
    in_valid <= 1'b0;

    while (board.expected_beats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    board.flush_leftovers();

    $display("Covered %0d register accesses, %0d result beats checked, %0d mismatches.",
             items_sent, board.beats_checked, board.fail_count);
    $display("Key sequence completed with pin mask %04h; %0d accesses ran under the lock.",
             lock_pins, items_sent - locked_from);
    if (board.fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/gpr_pkg.sv
rtl/gpr_regs.sv
rtl/gpio_port_registers_with_lock_top.sv
test/gpio_port_registers_with_lock_top_tb.sv
